// ===== rtl/hbfr_pkg.sv =====
// hbfr_pkg: shared types, constants and the crc-16 byte update for the heating bus
// frame receiver; no dependencies, compiled first
package hbfr_pkg;

	// longest telegram length a header may announce
	localparam int MAX_TELEGRAM_LENGTH = 32;

	// byte counter must hold MAX_TELEGRAM_LENGTH + 1 and still feed a 6-bit index
	localparam int CNT_NEED = $clog2(MAX_TELEGRAM_LENGTH + 2);
	localparam int CNT_W    = (CNT_NEED > 6) ? CNT_NEED : 6;
	localparam int IDX_W    = 6;

	// apb register map
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_BUS_MODE = 1'b0;
	localparam logic REG_OWN_ADDR = 1'b1;

	// start bytes, after the mode's inversion
	localparam logic [7:0] START_CRC_A = 8'hDC;
	localparam logic [7:0] START_CRC_B = 8'hDE;
	localparam logic [7:0] START_SUM   = 8'h78;
	localparam logic [7:0] START_REQ   = 8'h17;
	localparam logic [7:0] START_FIX_A = 8'h1D;
	localparam logic [7:0] START_FIX_B = 8'h1E;

	localparam logic [7:0]  INV_MASK      = 8'hFF;
	localparam logic [7:0]  REQ_ADDRESS   = 8'h01;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	// 257 * 256 modulo 2^16
	localparam logic [15:0] SUM_BIAS_BASE = 16'h0100;
	localparam logic [15:0] SUM_BIAS_TRIM = 16'd2;

	localparam logic [3:0] FIX_POS_DEFAULT = 4'd8;
	localparam logic [3:0] FIX_POS_REQ     = 4'd9;

	// header byte position per mode
	localparam logic [CNT_W-1:0] HDR_POS_CRC = CNT_W'(3);
	localparam logic [CNT_W-1:0] HDR_POS_SUM = CNT_W'(1);

	typedef enum logic [1:0] {
		MODE_CRC    = 2'd0,
		MODE_SUM    = 2'd1,
		MODE_FIXED  = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_CONT    = 2'd0,
		ST_GOOD    = 2'd1,
		ST_BAD_CHK = 2'd2,
		ST_LEN_ERR = 2'd3
	} status_t;

	typedef struct packed {
		mode_t      bus_mode;
		logic [7:0] own_address;
	} cfg_t;

	typedef struct packed {
		logic step;     // process the word held in the input register
		logic mode_wr;  // bus_mode write, drops any frame in progress
	} ctrl_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic             has_result;
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [IDX_W-1:0] byte_index;
		logic             last;
		status_t          status;
	} result_t;

	// one byte through crc-16 xmodem, msb first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== rtl/hbfr_req_if.sv =====
// hbfr_req_if: valid/ready channel carrying received bus words and gap events
// no dependencies
interface hbfr_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source(output valid, output req_type, output rx_byte, input ready);
	modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

// ===== rtl/hbfr_rsp_if.sv =====
// hbfr_rsp_if: valid/ready channel carrying rebuilt frame words and status
// no dependencies
interface hbfr_rsp_if;
	logic       valid;
	logic       ready;
	logic       data_valid;
	logic [7:0] data_byte;
	logic [5:0] byte_index;
	logic       last;
	logic [1:0] status;

	modport source(output valid, output data_valid, output data_byte, output byte_index,
		output last, output status, input ready);
	modport sink(input valid, input data_valid, input data_byte, input byte_index,
		input last, input status, output ready);
endinterface

// ===== rtl/heating_bus_frame_receiver.sv =====
// heating_bus_frame_receiver: top level, input register, result register and handshake
// depends on hbfr_pkg, hbfr_req_if, hbfr_rsp_if, hbfr_apb_regs, hbfr_frame_logic
//
// usage
//  req channel: one word per received bus byte (req_type 0) or per inter-byte gap
//  timeout (req_type 1); rx_byte is ignored on gaps
//  rsp channel: one word per frame byte, with its index; the closing word has last
//  set and carries the verdict (good, check failed, length error); a gap inside a
//  frame closes it with a word that has data_valid low; bytes outside a frame and
//  gaps while hunting give no word
//  apb port: bus_mode at 0x0, own_address at 0x4; write only while the block is idle;
//  a bus_mode write drops a frame in progress
// timing
//  a word accepted on req is registered in the input register, processed by the frame
//  logic and, when it gives a result, captured in the result register that drives rsp
//  one word per cycle sustained while rsp.ready stays high; the frame state loop (crc
//  byte update, sum and length compares) is combinational logic on the state registers
// reset and stall
//  arst_n clears all but the payload registers; the block comes up hunting in mode 0
//  while rsp is stalled the result register holds, one more word waits in the input
//  register, and req.ready drops until the result is taken
module heating_bus_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	hbfr_req_if.sink                    req,
	hbfr_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hbfr_pkg::ADDR_W-1:0] paddr,
	input  logic [hbfr_pkg::DATA_W-1:0] pwdata,
	output logic [hbfr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	hbfr_pkg::cfg_t    cfg;
	hbfr_pkg::ctrl_t   ctrl;
	hbfr_pkg::item_t   item_s1;
	hbfr_pkg::result_t res;
	logic              mode_wr;

	// input register
	logic              s1_valid_q;
	// result register
	logic              rsp_valid_q;
	hbfr_pkg::result_t rsp_q;

	logic              advance;

	// result register can take a new word when empty or being drained
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = !s1_valid_q || advance;

	assign ctrl.step    = s1_valid_q && advance;
	assign ctrl.mode_wr = mode_wr;

	hbfr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.mode_wr (mode_wr)
	);

	hbfr_frame_logic u_frame (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg),
		.item   (item_s1),
		.res    (res)
	);

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_q <= 1'b1;
		end else if (ctrl.step) begin
			s1_valid_q <= 1'b0;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.req_type <= req.req_type;
			item_s1.rx_byte  <= req.rx_byte;
		end
	end

	// result register control; a word with no result leaves it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= ctrl.step && res.has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.data_valid = rsp_q.data_valid;
	assign rsp.data_byte  = rsp_q.data_byte;
	assign rsp.byte_index = rsp_q.byte_index;
	assign rsp.last       = rsp_q.last;
	assign rsp.status     = rsp_q.status;

	// gap word always closes the frame with a length error
	a_gap_closes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.data_valid |-> rsp.last && (rsp.status == hbfr_pkg::ST_LEN_ERR))
		else $error("gap word without length error close");

	// status is only given on the closing word
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.last == (rsp.status != hbfr_pkg::ST_CONT)))
		else $error("status and last disagree");

	// a held input word survives a stalled result register
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(item_s1))
		else $error("input register lost a word during stall");

	// index never runs past MAX_TELEGRAM_LENGTH + 1
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (32'(rsp.byte_index) <= hbfr_pkg::MAX_TELEGRAM_LENGTH + 1))
		else $error("byte index out of range");

endmodule

// ===== rtl/hbfr_apb_regs.sv =====
// hbfr_apb_regs: apb configuration registers (bus_mode, own_address)
// depends on hbfr_pkg
module hbfr_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hbfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [hbfr_pkg::DATA_W-1:0]   pwdata,
	output logic [hbfr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output hbfr_pkg::cfg_t                cfg,
	output logic                          mode_wr
);

	logic           wr_en;
	logic           reg_idx;
	hbfr_pkg::cfg_t cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[hbfr_pkg::ADDR_W-1];
	assign mode_wr = wr_en & (reg_idx == hbfr_pkg::REG_BUS_MODE);
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_mode    <= hbfr_pkg::MODE_CRC;
			cfg_q.own_address <= 8'h00;
		end else if (wr_en) begin
			unique case (reg_idx)
				hbfr_pkg::REG_BUS_MODE: cfg_q.bus_mode    <= hbfr_pkg::mode_t'(pwdata[1:0]);
				hbfr_pkg::REG_OWN_ADDR: cfg_q.own_address <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hbfr_pkg::REG_BUS_MODE: prdata = {(hbfr_pkg::DATA_W-2)'(0), cfg_q.bus_mode};
			hbfr_pkg::REG_OWN_ADDR: prdata = {(hbfr_pkg::DATA_W-8)'(0), cfg_q.own_address};
			default:                prdata = '0;
		endcase
	end

endmodule

// ===== rtl/hbfr_frame_logic.sv =====
// hbfr_frame_logic: frame state registers and the one-pass result logic per word
// depends on hbfr_pkg
module hbfr_frame_logic (
	input  logic              clk,
	input  logic              arst_n,
	input  hbfr_pkg::ctrl_t   ctrl,
	input  hbfr_pkg::cfg_t    cfg,
	input  hbfr_pkg::item_t   item,
	output hbfr_pkg::result_t res
);

	localparam int CW = hbfr_pkg::CNT_W;

	logic          in_frame_q;
	logic [CW-1:0] count_q;
	logic [7:0]    hdr_len_q;
	logic [3:0]    fix_pos_q;
	logic [15:0]   crc_q;
	logic [15:0]   sum_q;
	logic [7:0]    prev_q;

	logic          is_fixed;
	logic          is_sum;
	logic [7:0]    b;
	logic          is_start;
	logic          req_frame;
	logic [CW-1:0] cur_count;
	logic [CW-1:0] new_count;
	logic [7:0]    cur_hdr;
	logic [7:0]    hdr_eff;
	logic [15:0]   cur_crc;
	logic [15:0]   crc_new;
	logic [15:0]   cur_sum;
	logic [7:0]    cur_prev;
	logic [3:0]    fix_pos_cur;
	logic [CW-1:0] hpos;
	logic [15:0]   total;
	logic [15:0]   bias;
	logic [15:0]   body;
	logic          sum_ok;
	logic          done;
	hbfr_pkg::status_t byte_status;
	logic          take_byte;

	assign is_fixed = (cfg.bus_mode == hbfr_pkg::MODE_FIXED);
	assign is_sum   = (cfg.bus_mode == hbfr_pkg::MODE_SUM);
	assign b        = is_fixed ? item.rx_byte : (item.rx_byte ^ hbfr_pkg::INV_MASK);

	always_comb begin
		case (cfg.bus_mode)
			hbfr_pkg::MODE_CRC:   is_start = (b == hbfr_pkg::START_CRC_A) ||
			                                 (b == hbfr_pkg::START_CRC_B);
			hbfr_pkg::MODE_SUM:   is_start = (b == hbfr_pkg::START_SUM);
			hbfr_pkg::MODE_FIXED: is_start = (b == hbfr_pkg::START_REQ) ||
			                                 (b == hbfr_pkg::START_FIX_A) ||
			                                 (b == hbfr_pkg::START_FIX_B);
			default:              is_start = 1'b0;
		endcase
	end

	// in fixed mode, a request start byte is a frame of its own when own_address is 1
	assign req_frame = is_fixed && (b == hbfr_pkg::START_REQ) &&
	                   (cfg.own_address == hbfr_pkg::REQ_ADDRESS);

	// a start byte sees freshly cleared state
	assign cur_count = in_frame_q ? count_q   : '0;
	assign cur_hdr   = in_frame_q ? hdr_len_q : 8'h00;
	assign cur_crc   = in_frame_q ? crc_q     : 16'h0000;
	assign cur_sum   = in_frame_q ? sum_q     : 16'h0000;
	assign cur_prev  = in_frame_q ? prev_q    : 8'h00;
	assign fix_pos_cur = in_frame_q ? fix_pos_q :
	                     ((is_fixed && (b == hbfr_pkg::START_REQ)) ?
	                      hbfr_pkg::FIX_POS_REQ : hbfr_pkg::FIX_POS_DEFAULT);

	assign new_count = cur_count + CW'(1);
	assign crc_new   = hbfr_pkg::crc_feed(cur_crc, b);
	assign hpos      = is_sum ? hbfr_pkg::HDR_POS_SUM : hbfr_pkg::HDR_POS_CRC;
	assign hdr_eff   = (cur_count == hpos) ? b : cur_hdr;
	assign total     = {8'h00, hdr_eff} + {15'd0, is_sum};

	// length-biased sum of the body against the two trailing bytes
	assign bias   = hbfr_pkg::SUM_BIAS_BASE - {hdr_eff, 8'h00} + {8'h00, hdr_eff}
	                - hbfr_pkg::SUM_BIAS_TRIM;
	assign body   = cur_sum - {8'h00, cur_prev};
	assign sum_ok = ((bias + body) == {cur_prev, b});

	always_comb begin
		done        = 1'b0;
		byte_status = hbfr_pkg::ST_CONT;
		if (is_fixed) begin
			if (16'(new_count) > {12'd0, fix_pos_cur}) begin
				done        = 1'b1;
				byte_status = hbfr_pkg::ST_GOOD;
			end
		end else if (new_count > hpos) begin
			if (32'(hdr_eff) > hbfr_pkg::MAX_TELEGRAM_LENGTH) begin
				done        = 1'b1;
				byte_status = hbfr_pkg::ST_LEN_ERR;
			end else if (16'(new_count) >= total) begin
				done = 1'b1;
				if (16'(new_count) != total) begin
					byte_status = hbfr_pkg::ST_LEN_ERR;
				end else if (is_sum) begin
					byte_status = sum_ok ? hbfr_pkg::ST_GOOD : hbfr_pkg::ST_BAD_CHK;
				end else begin
					byte_status = (crc_new == 16'h0000) ? hbfr_pkg::ST_GOOD :
					                                      hbfr_pkg::ST_BAD_CHK;
				end
			end
		end
	end

	// byte that belongs to a frame and moves the state
	assign take_byte = !item.req_type && (in_frame_q || (is_start && !req_frame));

	always_comb begin
		res = '0;
		if (item.req_type) begin
			// gap closes an open frame with a length error
			res.has_result = in_frame_q;
			res.byte_index = count_q[hbfr_pkg::IDX_W-1:0];
			res.last       = 1'b1;
			res.status     = hbfr_pkg::ST_LEN_ERR;
		end else if (!in_frame_q && is_start && req_frame) begin
			res.has_result = 1'b1;
			res.data_valid = 1'b1;
			res.data_byte  = b;
			res.last       = 1'b1;
			res.status     = hbfr_pkg::ST_GOOD;
		end else begin
			res.has_result = take_byte;
			res.data_valid = 1'b1;
			res.data_byte  = b;
			res.byte_index = cur_count[hbfr_pkg::IDX_W-1:0];
			res.last       = done;
			res.status     = byte_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			hdr_len_q  <= 8'h00;
			fix_pos_q  <= hbfr_pkg::FIX_POS_DEFAULT;
			crc_q      <= 16'h0000;
			sum_q      <= 16'h0000;
			prev_q     <= 8'h00;
		end else if (ctrl.mode_wr) begin
			in_frame_q <= 1'b0;
			fix_pos_q  <= hbfr_pkg::FIX_POS_DEFAULT;
		end else if (ctrl.step) begin
			if (item.req_type) begin
				if (in_frame_q) begin
					in_frame_q <= 1'b0;
					fix_pos_q  <= hbfr_pkg::FIX_POS_DEFAULT;
				end
			end else if (take_byte) begin
				in_frame_q <= !done;
				count_q    <= new_count;
				hdr_len_q  <= hdr_eff;
				crc_q      <= crc_new;
				sum_q      <= cur_sum + {8'h00, b};
				prev_q     <= b;
				fix_pos_q  <= done ? hbfr_pkg::FIX_POS_DEFAULT : fix_pos_cur;
			end
		end
	end

endmodule
